[rtl/bomp_pkg.sv]
// Shared types and constants for the band onset merge and peak picker.
// Used by every module of the block; depends on nothing.
package bomp_pkg;

  localparam int unsigned BANDS      = 8;
  localparam int unsigned BAND_LIMIT = 12;
  localparam int unsigned BAND_W     = 16;
  localparam int unsigned WEIGHT_W   = 4;
  localparam int unsigned PROD_W     = BAND_W + WEIGHT_W;
  localparam int unsigned ACC_W      = PROD_W + $clog2(BAND_LIMIT);
  localparam int unsigned STR_W      = 19;
  localparam int unsigned POS_W      = 32;
  localparam int unsigned DIST_W     = 16;

  localparam int unsigned S_TDATA_W = ((BANDS * BAND_W + 7) / 8) * 8;
  localparam int unsigned M_TDATA_W = ((POS_W + STR_W + 7) / 8) * 8;

  localparam logic [STR_W-1:0] STRENGTH_MAX = {STR_W{1'b1}};

  localparam logic [WEIGHT_W-1:0] BAND_WEIGHT [BAND_LIMIT] = '{
    4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1,
    4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1
  };

  // Control that travels with one sample down the pipeline.
  typedef struct packed {
    logic valid;
    logic last;
  } pipe_ctl_t;

endpackage

[rtl/bomp_lane.sv]
// One band lane: weight a band strength and register the product.
// Depends on bomp_pkg.
module bomp_lane
  import bomp_pkg::*;
(
  input  logic                clk_i,
  input  logic                adv_i,
  input  logic [BAND_W-1:0]   band_i,
  input  logic [WEIGHT_W-1:0] weight_i,
  output logic [PROD_W-1:0]   prod_o
);

  logic [PROD_W-1:0] prod_q, prod_d;

  assign prod_d = PROD_W'(band_i) * PROD_W'(weight_i);

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      prod_q <= prod_d;
    end
  end

  assign prod_o = prod_q;

endmodule

[rtl/bomp_merge.sv]
// Merge stage: sum the lane products, saturate to the strength width, register.
// Depends on bomp_pkg.
module bomp_merge
  import bomp_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              adv_i,
  input  logic [PROD_W-1:0] prod_i [BANDS],
  input  pipe_ctl_t         ctl_i,
  output logic [STR_W-1:0]  strength_o,
  output pipe_ctl_t         ctl_o
);

  logic [ACC_W-1:0] acc;
  logic [STR_W-1:0] strength_q, strength_d;
  pipe_ctl_t        ctl_q;

  always_comb begin
    acc = '0;
    for (int unsigned b = 0; b < BANDS; b++) begin
      acc = acc + ACC_W'(prod_i[b]);
    end
    strength_d = (acc > ACC_W'(STRENGTH_MAX)) ? STRENGTH_MAX : acc[STR_W-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl_q <= '0;
    end else if (adv_i) begin
      ctl_q <= ctl_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      strength_q <= strength_d;
    end
  end

  assign strength_o = strength_q;
  assign ctl_o      = ctl_q;

endmodule

[rtl/bomp_picker.sv]
// Peak picker: window tracking, best onset and the output register.
// Depends on bomp_pkg.
module bomp_picker
  import bomp_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              adv_i,
  input  logic [DIST_W-1:0] min_dist_i,
  input  logic [STR_W-1:0]  strength_i,
  input  pipe_ctl_t         ctl_i,
  output logic              out_valid_o,
  output logic [POS_W-1:0]  out_pos_o,
  output logic [STR_W-1:0]  out_str_o
);

  logic [POS_W-1:0]  idx_q, idx_d;
  logic              open_q, open_d;
  logic [STR_W-1:0]  best_q, best_d;
  logic [POS_W-1:0]  bpos_q, bpos_d;
  logic [DIST_W-1:0] left_q, left_d;
  logic              ovld_q, ovld_d;
  logic [POS_W-1:0]  opos_q;
  logic [STR_W-1:0]  ostr_q;
  logic [DIST_W-1:0] reload;
  logic              emit;

  // A zero length acts as one.
  assign reload = (min_dist_i == '0) ? '0 : min_dist_i - DIST_W'(1);

  always_comb begin
    idx_d  = idx_q;
    open_d = open_q;
    best_d = best_q;
    bpos_d = bpos_q;
    left_d = left_q;
    emit   = 1'b0;
    if (ctl_i.valid) begin
      if (!open_q) begin
        if (strength_i != '0) begin
          open_d = 1'b1;
          best_d = strength_i;
          bpos_d = idx_q;
          left_d = reload;
        end
      end else if (strength_i > best_q) begin
        best_d = strength_i;
        bpos_d = idx_q;
        left_d = reload;
      end else if (left_q != '0) begin
        left_d = left_q - DIST_W'(1);
      end
      // Close the window on its last sample or at stream end.
      if (open_d && (left_d == '0 || ctl_i.last)) begin
        emit   = 1'b1;
        open_d = 1'b0;
        left_d = '0;
      end
      idx_d = ctl_i.last ? '0 : idx_q + POS_W'(1);
    end
    ovld_d = emit;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q  <= '0;
      open_q <= 1'b0;
      best_q <= '0;
      bpos_q <= '0;
      left_q <= '0;
      ovld_q <= 1'b0;
    end else if (adv_i) begin
      idx_q  <= idx_d;
      open_q <= open_d;
      best_q <= best_d;
      bpos_q <= bpos_d;
      left_q <= left_d;
      ovld_q <= ovld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i && emit) begin
      opos_q <= bpos_d;
      ostr_q <= best_d;
    end
  end

  assign out_valid_o = ovld_q;
  assign out_pos_o   = opos_q;
  assign out_str_o   = ostr_q;

endmodule

[rtl/band_onset_merge_peak_pick.sv]
// Top level of the band onset merge and peak picker.
// Depends on bomp_pkg, bomp_lane, bomp_merge and bomp_picker.
//
// Usage:
//   Slave stream: one transaction per time sample. tdata carries the band
//   strengths, band 0 in the lowest 16 bits; tlast marks the end of stream.
//   Master stream: one transaction per kept onset, position in the low 32
//   bits of tdata and summed strength above it.
//   Configuration: cfg_we_i writes min_dist (window length in samples); write
//   only while the block is idle. A new length applies at the next reload.
// Path: a result reaches the master side through the lane register, which
//   takes the input transaction closing its window, then the sum register,
//   then the output register; a stall holds every stage.
// Throughput: one sample per cycle while no result waits unclaimed, set by the
//   three-stage pipeline, a combinational eight-input adder tree and window compare.
// Reset: clears the window state, the sample index, all valid flags and sets
//   min_dist to one.
// Stall: while a result waits and the receiver holds tready low, the whole
//   pipeline holds and s_axis_tready_o drops; it stays high otherwise, also
//   while samples are in flight.
module band_onset_merge_peak_pick
  import bomp_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  // band0..band7, 16 bits each, band0 lowest
  input  logic [S_TDATA_W-1:0] s_axis_tdata_i,
  input  logic                 s_axis_tlast_i,   // end_of_stream
  input  logic                 s_axis_tvalid_i,
  output logic                 s_axis_tready_o,
  // onset_position [31:0], onset_strength [50:32], zero padding above
  output logic [M_TDATA_W-1:0] m_axis_tdata_o,
  output logic                 m_axis_tvalid_o,
  input  logic                 m_axis_tready_i,
  input  logic                 cfg_we_i,
  input  logic [DIST_W-1:0]    cfg_wdata_i
);

  logic              adv;
  logic [DIST_W-1:0] min_dist_q;
  pipe_ctl_t         ctl1_q, ctl1_d, ctl2;
  logic [PROD_W-1:0] prod [BANDS];
  logic [STR_W-1:0]  strength;
  logic              out_valid;
  logic [POS_W-1:0]  out_pos;
  logic [STR_W-1:0]  out_str;

  // Advance every stage unless a result sits unclaimed at the output.
  assign adv             = !out_valid || m_axis_tready_i;
  assign s_axis_tready_o = adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_dist_q <= DIST_W'(1);
    end else if (cfg_we_i) begin
      min_dist_q <= cfg_wdata_i;
    end
  end

  assign ctl1_d.valid = s_axis_tvalid_i;
  assign ctl1_d.last  = s_axis_tlast_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl1_q <= '0;
    end else if (adv) begin
      ctl1_q <= ctl1_d;
    end
  end

  // One weighting lane per band.
  for (genvar g = 0; g < BANDS; g++) begin : g_lane
    bomp_lane u_lane (
      .clk_i    (clk_i),
      .adv_i    (adv),
      .band_i   (s_axis_tdata_i[g*BAND_W +: BAND_W]),
      .weight_i (BAND_WEIGHT[g]),
      .prod_o   (prod[g])
    );
  end

  bomp_merge u_merge (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .adv_i      (adv),
    .prod_i     (prod),
    .ctl_i      (ctl1_q),
    .strength_o (strength),
    .ctl_o      (ctl2)
  );

  bomp_picker u_picker (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .adv_i       (adv),
    .min_dist_i  (min_dist_q),
    .strength_i  (strength),
    .ctl_i       (ctl2),
    .out_valid_o (out_valid),
    .out_pos_o   (out_pos),
    .out_str_o   (out_str)
  );

  assign m_axis_tvalid_o = out_valid;
  assign m_axis_tdata_o  = M_TDATA_W'({out_str, out_pos});

endmodule

[rtl/bomp_checker.sv]
// Port-level checks for band_onset_merge_peak_pick, bound to the top level.
// Depends on bomp_pkg.
module bomp_checker
  import bomp_pkg::*;
(
  input logic                 clk_i,
  input logic                 rst_ni,
  input logic                 s_axis_tready_o,
  input logic [M_TDATA_W-1:0] m_axis_tdata_o,
  input logic                 m_axis_tvalid_o,
  input logic                 m_axis_tready_i
);

  // Hold a stalled result.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=> m_axis_tvalid_o && $stable(m_axis_tdata_o))
    else $error("stalled result changed");

  // Never block input while the output is free.
  a_ready_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !m_axis_tvalid_o |-> s_axis_tready_o)
    else $error("input blocked with empty output");

  // A kept onset always has nonzero strength.
  a_str_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> m_axis_tdata_o[POS_W +: STR_W] != '0)
    else $error("onset with zero strength");

  // Leave reset with no result pending.
  a_reset_empty: assert property (@(posedge clk_i)
    $rose(rst_ni) |-> !m_axis_tvalid_o)
    else $error("result pending out of reset");

endmodule

bind band_onset_merge_peak_pick bomp_checker u_bomp_checker (.*);

[verif/tb.sv]
`timescale 1ns / 1ps
// Self-checking testbench for band_onset_merge_peak_pick: stream traffic, predictor and checker.
// Depends on bomp_pkg and the RTL of the block; needs no other file.

module tb;
  import bomp_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam int unsigned DRAIN_CYCLES = 8;  // three pipeline stages plus margin
  localparam int unsigned REPORT_LIMIT = 100;

  typedef logic [BANDS-1:0][BAND_W-1:0] band_vec_t;

  typedef struct packed {
    logic [POS_W-1:0] position;
    logic [STR_W-1:0] strength;
  } onset_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  logic [S_TDATA_W-1:0] s_data = '0;
  logic                 s_last = 1'b0;
  logic                 s_valid = 1'b0;
  logic                 s_ready;
  logic [M_TDATA_W-1:0] m_data;
  logic                 m_valid;
  logic                 m_ready = 1'b0;
  logic                 cfg_we = 1'b0;
  logic [DIST_W-1:0]    cfg_wdata = '0;

  // Traffic shaping, changed by the tests between phases.
  int unsigned idle_pct = 0;
  int unsigned stall_pct = 0;
  int unsigned hold_left = 0;

  int unsigned fail_count = 0;
  int unsigned cycle_count = 0;

  // Onsets predicted but not yet seen on the master side, oldest first.
  onset_t pending_onsets[$];

  // Predictor state: mirrors the picker's window and position tracking.
  logic [DIST_W-1:0] dist_setting = 16'd1;
  logic [POS_W-1:0]  pos_count = '0;
  logic              searching = 1'b0;
  logic [STR_W-1:0]  peak_strength = '0;
  logic [POS_W-1:0]  peak_pos = '0;
  logic [DIST_W-1:0] cnt_left = '0;

  band_onset_merge_peak_pick DUT (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tdata_i  (s_data),
    .s_axis_tlast_i  (s_last),
    .s_axis_tvalid_i (s_valid),
    .s_axis_tready_o (s_ready),
    .m_axis_tdata_o  (m_data),
    .m_axis_tvalid_o (m_valid),
    .m_axis_tready_i (m_ready),
    .cfg_we_i        (cfg_we),
    .cfg_wdata_i     (cfg_wdata)
  );

  initial begin
    forever begin
      #4 clk_i = ~clk_i;
    end
  end

  // Bound the run; a hang anywhere ends here.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("%0t: timeout with %0d onsets outstanding", $time, pending_onsets.size());
      $display("Some tests failed");
      $finish;
    end
  end

  // Predict the onset, if any, that each accepted sample closes. Configuration
  // writes are taken on the same edge as the block takes them.
  always @(posedge clk_i) begin : predict_onsets
    int unsigned total;
    logic [STR_W-1:0] sum;
    logic [DIST_W-1:0] reload;
    logic eos;
    onset_t hit;
    if (rst_ni) begin
      if (cfg_we) begin
        dist_setting = cfg_wdata;
      end
      if (s_valid && s_ready) begin
        total = 0;
        for (int b = 0; b < BANDS; b++) begin
          total += s_data[b*BAND_W +: BAND_W];
        end
        // Saturate the merged strength at the top of its range.
        sum = (total > {STR_W{1'b1}}) ? {STR_W{1'b1}} : total[STR_W-1:0];
        eos = s_last;
        // A zero length behaves like a length of one.
        reload = (dist_setting == '0) ? '0 : dist_setting - 1'b1;
        if (!searching) begin
          if (sum != '0) begin
            searching = 1'b1;
            peak_strength = sum;
            peak_pos = pos_count;
            cnt_left = reload;
          end
        end else if (sum > peak_strength) begin
          // Strictly stronger: move the peak and restart the window here.
          peak_strength = sum;
          peak_pos = pos_count;
          cnt_left = reload;
        end else if (cnt_left != '0) begin
          cnt_left = cnt_left - 1'b1;
        end
        if (searching && (cnt_left == '0 || eos)) begin
          hit.position = peak_pos;
          hit.strength = peak_strength;
          pending_onsets.push_back(hit);
          searching = 1'b0;
          cnt_left = '0;
        end
        pos_count = eos ? '0 : pos_count + 1'b1;
      end
    end
  end

  task automatic report_mismatch(input string what, input logic [POS_W-1:0] want,
                                 input logic [POS_W-1:0] got);
    fail_count++;
    if (fail_count <= REPORT_LIMIT) begin
      $display("%0t: %s mismatch, expected %0d actual %0d", $time, what, want, got);
    end
  endtask

  // Compare every master transaction with the oldest predicted onset.
  always @(posedge clk_i) begin : check_onsets
    onset_t want;
    onset_t got;
    if (rst_ni && m_valid && m_ready) begin
      got.position = m_data[POS_W-1:0];
      got.strength = m_data[POS_W +: STR_W];
      if (pending_onsets.size() == 0) begin
        fail_count++;
        if (fail_count <= REPORT_LIMIT) begin
          $display("%0t: unexpected onset, expected none actual pos %0d strength %0d",
                   $time, got.position, got.strength);
        end
      end else begin
        want = pending_onsets.pop_front();
        if (got.position !== want.position) begin
          report_mismatch("onset_position", want.position, got.position);
        end
        if (got.strength !== want.strength) begin
          report_mismatch("onset_strength", POS_W'(want.strength), POS_W'(got.strength));
        end
      end
    end
  end

  // Receiver: random stalls, or a counted hold-off when a test asks for one.
  initial begin
    forever begin
      @(negedge clk_i);
      if (hold_left > 0) begin
        m_ready <= 1'b0;
        hold_left = hold_left - 1;
      end else begin
        m_ready <= ($urandom_range(99) >= stall_pct);
      end
    end
  end

  // Offer one sample and hold it until the block takes it. Enter and leave at
  // a falling edge; valid stays high so back-to-back transactions need no gap.
  task automatic send_sample(input band_vec_t bands, input logic eos);
    while ($urandom_range(99) < idle_pct) begin
      s_valid <= 1'b0;
      @(negedge clk_i);
    end
    s_data <= S_TDATA_W'(bands);
    s_last <= eos;
    s_valid <= 1'b1;
    do begin
      @(posedge clk_i);
    end while (!s_ready);
    @(negedge clk_i);
  endtask

  // Drop valid, wait for every predicted onset, then let the pipeline empty
  // of samples that close nothing.
  task automatic wait_for_quiet();
    s_valid <= 1'b0;
    while (pending_onsets.size() != 0) begin
      @(negedge clk_i);
    end
    repeat (DRAIN_CYCLES) @(negedge clk_i);
  endtask

  task automatic set_min_dist(input logic [DIST_W-1:0] win_len);
    wait_for_quiet();
    cfg_we <= 1'b1;
    cfg_wdata <= win_len;
    @(negedge clk_i);
    cfg_we <= 1'b0;
  endtask

  function automatic band_vec_t all_bands(input logic [BAND_W-1:0] v);
    band_vec_t vec;
    for (int b = 0; b < BANDS; b++) begin
      vec[b] = v;
    end
    return vec;
  endfunction

  function automatic band_vec_t one_band(input int idx, input logic [BAND_W-1:0] v);
    band_vec_t vec;
    vec = '0;
    vec[idx] = v;
    return vec;
  endfunction

  // Random sample shaped to open, restart, tie and close windows.
  function automatic band_vec_t next_bands(input band_vec_t prev);
    band_vec_t vec;
    int unsigned kind;
    int unsigned bumped;
    kind = $urandom_range(99);
    vec = '0;
    for (int b = 0; b < BANDS; b++) begin
      if (kind < 30) begin
        vec[b] = '0;
      end else if (kind < 50) begin
        vec[b] = BAND_W'($urandom_range(15));
      end else if (kind < 65) begin
        vec[b] = '0;
      end else if (kind < 80) begin
        bumped = prev[b] + $urandom_range(3);
        vec[b] = (bumped > 16'hFFFF) ? 16'hFFFF : BAND_W'(bumped);
      end else if (kind < 88) begin
        vec[b] = prev[b];
      end else begin
        vec[b] = BAND_W'($urandom);
      end
    end
    if (kind >= 50 && kind < 65) begin
      vec[$urandom_range(BANDS - 1)] = BAND_W'($urandom);
    end
    return vec;
  endfunction

  // Reset value of min_dist is one: every positive sample is its own onset.
  // Covers empty samples, the largest sum, the smallest sum and all bit values.
  task automatic test_reset_defaults();
    send_sample(all_bands(16'h0000), 1'b0);
    send_sample(all_bands(16'hFFFF), 1'b0);
    send_sample(one_band(0, 16'h0001), 1'b0);
    send_sample(one_band(BANDS - 1, 16'h8000), 1'b0);
    send_sample(all_bands(16'h5555), 1'b0);
    send_sample(all_bands(16'hAAAA), 1'b0);
    send_sample(all_bands(16'h0000), 1'b1);
  endtask

  // Stronger sample restarts the window, an equal one does not; stream end
  // closes an open window, even the one it opens itself.
  task automatic test_window_restart();
    set_min_dist(16'd4);
    send_sample(one_band(0, 16'd5), 1'b0);
    send_sample(one_band(1, 16'd3), 1'b0);
    send_sample(one_band(2, 16'd7), 1'b0);
    send_sample(one_band(3, 16'd7), 1'b0);
    send_sample(all_bands(16'd0), 1'b0);
    send_sample(all_bands(16'd0), 1'b0);
    send_sample(one_band(4, 16'd2), 1'b0);
    send_sample(one_band(5, 16'd1), 1'b1);
    send_sample(one_band(6, 16'd20), 1'b1);
  endtask

  // A length of zero acts as one.
  task automatic test_zero_length();
    set_min_dist(16'd0);
    send_sample(one_band(0, 16'd9), 1'b0);
    send_sample(one_band(1, 16'd9), 1'b0);
    send_sample(all_bands(16'd0), 1'b0);
    send_sample(one_band(2, 16'd4), 1'b1);
  endtask

  // A new length written while a window is open applies at the next reload.
  task automatic test_length_change_mid_window();
    set_min_dist(16'd3);
    send_sample(one_band(3, 16'd6), 1'b0);
    set_min_dist(16'd10);
    send_sample(all_bands(16'd0), 1'b0);
    send_sample(all_bands(16'd0), 1'b0);
    send_sample(one_band(4, 16'd6), 1'b0);
    send_sample(all_bands(16'd0), 1'b1);
  endtask

  // Longest window: only the stream end closes it.
  task automatic test_max_length();
    set_min_dist(16'hFFFF);
    send_sample(one_band(0, 16'd100), 1'b0);
    send_sample(one_band(1, 16'd50), 1'b0);
    send_sample(one_band(2, 16'd200), 1'b0);
    send_sample(all_bands(16'd0), 1'b1);
  endtask

  // Hold the receiver off while samples keep coming so the block fills and
  // drops s_axis_tready_o; every sample here closes its own window.
  task automatic test_backpressure();
    idle_pct = 0;
    stall_pct = 0;
    set_min_dist(16'd1);
    hold_left = 300;
    for (int i = 0; i < 60; i++) begin
      send_sample(one_band(i % BANDS, BAND_W'($urandom_range(1, 16'hFFFF))), i == 59);
    end
  endtask

  // Mostly well-formed streams ending in tlast, some broken ones with tlast
  // anywhere or missing, across idle and receiver-stall phases and window lengths.
  task automatic test_random_streams();
    int unsigned idle_tab[4];
    int unsigned stall_tab[4];
    int unsigned sent;
    int unsigned len;
    int unsigned pick;
    logic [DIST_W-1:0] win_len;
    logic broken;
    logic eos;
    band_vec_t bands;
    idle_tab = '{0, 84, 0, 34};
    stall_tab = '{0, 0, 84, 34};
    bands = '0;
    for (int phase = 0; phase < 4; phase++) begin
      for (int seg = 0; seg < 4; seg++) begin
        pick = $urandom_range(99);
        if (seg == 0) begin
          win_len = 16'd1;
        end else if (seg == 3 && phase == 1) begin
          win_len = 16'hFFFF;
        end else if (pick < 60) begin
          win_len = DIST_W'($urandom_range(2, 8));
        end else if (pick < 92) begin
          win_len = DIST_W'($urandom_range(9, 64));
        end else begin
          win_len = DIST_W'($urandom_range(65, 16'hFFFE));
        end
        set_min_dist(win_len);
        idle_pct = idle_tab[phase];
        stall_pct = stall_tab[phase];
        sent = 0;
        while (sent < 70) begin
          len = $urandom_range(1, 40);
          broken = ($urandom_range(99) < 15);
          for (int k = 0; k < len; k++) begin
            bands = next_bands(bands);
            eos = broken ? ($urandom_range(7) == 0) : (k == len - 1);
            send_sample(bands, eos);
            sent++;
          end
        end
      end
    end
    idle_pct = 0;
    stall_pct = 0;
  endtask

  initial begin
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    test_reset_defaults();
    test_window_restart();
    test_zero_length();
    test_length_change_mid_window();
    test_max_length();
    test_backpressure();
    test_random_streams();

    wait_for_quiet();
    if (pending_onsets.size() != 0) begin
      fail_count += pending_onsets.size();
    end
    if (fail_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
